/* rtl/gf256_inverse_euclid_defines.svh */
// Assertion macros shared by the GF(2^8) inverse controller and datapath.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef GF256_INVERSE_EUCLID_DEFINES_SVH
`define GF256_INVERSE_EUCLID_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define GFINV_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define GFINV_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* rtl/gfinv_pkg.sv */
// Package for the GF(2^8) inverse block: state type, command and status structs,
// polynomial degree and field multiply functions. Depends on nothing.
package gfinv_pkg;

	localparam int unsigned VAL_W = 8;
	localparam int unsigned POLY_W = 9;
	localparam int unsigned DEG_W = 4;
	localparam int unsigned SH_W = 3;

	localparam logic [POLY_W-1:0] GF_REDUCER = 9'h11B;
	localparam logic [POLY_W-1:0] MODULUS_RESET = 9'h11B;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_DIV
	} state_t;

	typedef struct packed {
		logic load;
		logic check;
		logic finish;
		logic div_step;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic cur_one;
		logic cur_zero;
		logic div_done;
	} status_t;

	function automatic logic [DEG_W-1:0] poly_degree(input logic [POLY_W-1:0] x);
		logic [DEG_W-1:0] d;
		d = '0;
		for (int i = 0; i < POLY_W; i++) begin
			if (x[i]) begin
				d = DEG_W'(i);
			end
		end
		return d;
	endfunction

	function automatic logic [VAL_W-1:0] gf_mul(input logic [VAL_W-1:0] a_in,
			input logic [VAL_W-1:0] b);
		logic [VAL_W-1:0] acc;
		logic [POLY_W-1:0] a;
		acc = '0;
		a = {1'b0, a_in};
		for (int i = 0; i < VAL_W; i++) begin
			if (b[i]) begin
				acc = acc ^ a[VAL_W-1:0];
			end
			a = {a[POLY_W-2:0], 1'b0};
			if (a[POLY_W-1]) begin
				a = a ^ GF_REDUCER;
			end
		end
		return acc;
	endfunction

endpackage

/* rtl/gfinv_dpath.sv */
// Datapath of the GF(2^8) inverse: remainder and coefficient registers, one long-division
// step per cycle while div_step is high, field multiply on update. Uses gfinv_pkg.
`include "gf256_inverse_euclid_defines.svh"
module gfinv_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [8:0]           cfg_wdata,
	input  logic [7:0]           value,
	input  gfinv_pkg::cmd_t      cmd,
	output gfinv_pkg::status_t   status,
	output logic                 done,
	output logic [7:0]           inverse,
	output logic                 no_inverse
);
	import gfinv_pkg::*;

	logic [POLY_W-1:0] modulus_q;
	logic [POLY_W-1:0] prev_r_q;
	logic [POLY_W-1:0] cur_r_q;
	logic [POLY_W-1:0] num_q;
	logic [VAL_W-1:0]  prev_t_q;
	logic [VAL_W-1:0]  cur_t_q;
	logic [VAL_W-1:0]  quot_q;
	logic              zero_in_q;
	logic              done_q;
	logic [VAL_W-1:0]  inverse_q;
	logic              no_inverse_q;

	logic [DEG_W-1:0]  deg_num;
	logic [DEG_W-1:0]  deg_div;
	logic [DEG_W-1:0]  deg_diff;
	logic [SH_W-1:0]   shift;
	logic [POLY_W-1:0] num_next;
	logic [VAL_W-1:0]  quot_next;
	logic [VAL_W-1:0]  t_next;

	always_comb begin
		deg_num   = poly_degree(num_q);
		deg_div   = poly_degree(cur_r_q);
		deg_diff  = deg_num - deg_div;
		shift     = deg_diff[SH_W-1:0];
		num_next  = num_q ^ (cur_r_q << shift);
		quot_next = quot_q ^ (VAL_W'(1) << shift);
		t_next    = prev_t_q ^ gf_mul(quot_q, cur_t_q);
		status.cur_one  = (cur_r_q == POLY_W'(1));
		status.cur_zero = (cur_r_q == '0);
		status.div_done = (num_q == '0) || (deg_num < deg_div);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prev_r_q  <= modulus_q;
			cur_r_q   <= {1'b0, value};
			prev_t_q  <= '0;
			cur_t_q   <= VAL_W'(1);
			zero_in_q <= (value == '0);
		end else if (cmd.update) begin
			prev_r_q <= cur_r_q;
			cur_r_q  <= num_q;
			prev_t_q <= cur_t_q;
			cur_t_q  <= t_next;
		end
		if (cmd.check) begin
			num_q  <= prev_r_q;
			quot_q <= '0;
		end else if (cmd.div_step) begin
			num_q  <= num_next;
			quot_q <= quot_next;
		end
		if (cmd.finish) begin
			inverse_q    <= status.cur_one ? cur_t_q : '0;
			no_inverse_q <= !status.cur_one && !zero_in_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done       = done_q;
	assign inverse    = inverse_q;
	assign no_inverse = no_inverse_q;

	`GFINV_ASSERT_NOW(a_update_after_division, cmd.update, status.div_done,
		"Coefficient update issued before the division finished.")
	`GFINV_ASSERT_NOW(a_step_nontrivial_divisor, cmd.div_step,
		!status.cur_one && !status.cur_zero, "Division step with a divisor of zero or one.")
	`GFINV_ASSERT_NEXT(a_done_single_pulse, done_q, !done_q,
		"Result strobe lasted more than one cycle.")

endmodule

/* rtl/gfinv_ctrl.sv */
// Controller of the GF(2^8) inverse: sequences load, remainder check,
// division steps, update and finish. Uses gfinv_pkg.
`include "gf256_inverse_euclid_defines.svh"
module gfinv_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  gfinv_pkg::status_t   status,
	output gfinv_pkg::cmd_t      cmd,
	output logic                 busy
);
	import gfinv_pkg::*;

	state_t state_q;
	state_t state_next;

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_next = S_CHECK;
				end
			end
			S_CHECK: begin
				if (status.cur_one || status.cur_zero) begin
					state_next = S_IDLE;
				end else begin
					state_next = S_DIV;
				end
			end
			S_DIV: begin
				if (status.div_done) begin
					state_next = S_CHECK;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_CHECK: begin
				cmd.check  = 1'b1;
				cmd.finish = status.cur_one || status.cur_zero;
			end
			S_DIV: begin
				cmd.div_step = !status.div_done;
				cmd.update   = status.div_done;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	`GFINV_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy,
		"Accepted request did not make the block busy.")
	`GFINV_ASSERT_NEXT(a_finish_goes_idle, cmd.finish, !busy,
		"Block stayed busy after delivering a result.")
	`GFINV_ASSERT_NEXT(a_division_returns_to_check, state_q == S_DIV && status.div_done,
		state_q == S_CHECK, "Finished division did not return to the remainder check.")

endmodule

/* rtl/gf256_inverse_euclid.sv */
// Top level of the GF(2^8) multiplicative inverse by the extended Euclidean
// algorithm. Instantiates gfinv_ctrl and gfinv_dpath; uses gfinv_pkg.
//
// Channel   Ports                         Handshake
// request   start, value                  taken when start is high and busy is low
// result    done, inverse, no_inverse     valid for the single cycle done is high
// config    cfg_we, cfg_wdata             modulus written when cfg_we is high
//
// A request of zero or one goes from the load straight to a remainder check that finishes it.
// Otherwise each Euclid round runs one remainder check, one division step per quotient
// term and one update, until a check finds a remainder of zero or one.
// One request is in work at a time; busy stays high until the result is registered.
// Reset sets the modulus to 0x11B and clears the controller and result strobe.
// The receiver cannot stall; a result register holds until the next result.
module gf256_inverse_euclid (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [7:0] value,
	output logic       busy,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	output logic       done,
	output logic [7:0] inverse,
	output logic       no_inverse
);
	import gfinv_pkg::*;

	cmd_t    cmd;
	status_t status;

	gfinv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	gfinv_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.value      (value),
		.cmd        (cmd),
		.status     (status),
		.done       (done),
		.inverse    (inverse),
		.no_inverse (no_inverse)
	);

endmodule
